// ===== hw/rtl/nce_pkg.sv =====
// ----------------------------------------------------------------------------
// nce_pkg
// Shared types and constants of the nonzero coordinate emitter.
// ----------------------------------------------------------------------------
package nce_pkg;

  // Fixed field widths
  localparam int NUM_DIM_REGS = 6;   // dimension size registers
  localparam int RANK_W       = 3;   // rank register / tuple rank
  localparam int DIM_SIZE_W   = 16;  // dimension size register
  localparam int COORD_W      = 16;  // coordinate output
  localparam int DIM_IDX_W    = 3;   // dimension number output

  // APB register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Depth of the tuple queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_RANK  = 3'd0,
    REG_DIM_0 = 3'd1,
    REG_DIM_1 = 3'd2,
    REG_DIM_2 = 3'd3,
    REG_DIM_3 = 3'd4,
    REG_DIM_4 = 3'd5,
    REG_DIM_5 = 3'd6
  } nce_reg_idx_t;

  // Configuration seen by the front end
  typedef struct packed {
    logic [RANK_W-1:0]                         rank;
    logic [NUM_DIM_REGS-1:0][DIM_SIZE_W-1:0]   dim_size;
  } nce_cfg_t;

endpackage

// ===== hw/rtl/nonzero_coordinate_emitter.sv =====
// ----------------------------------------------------------------------------
// nonzero_coordinate_emitter
// Streams a tensor in row-major order and emits the coordinates of every
// nonzero element, outermost dimension first.
// ----------------------------------------------------------------------------
// Elements enter one per beat on the in_ queue port. Every accepted element,
// zero or not, steps a per-dimension odometer (innermost active dimension
// fastest, all counters wrap to zero after the tensor's last element). A
// nonzero element produces one output beat per active dimension, carrying
// the coordinate, the dimension number (0 = outermost) and a last flag on
// the innermost one; zero elements produce nothing. Input accepts one
// element per clock as long as the 4-entry tuple queue has room, and the
// output drains one coordinate per clock while out_pop is held; the output
// port sets the sustained rate. With the block empty, the first coordinate
// reaches the output through the queue write and then the output register
// load. Rank (1..6, 0 acts as 1) and dimension sizes are set through the
// APB port at byte addresses 0x00 (rank) and 0x04..0x18 (dimension 0..5);
// write them only while the block is idle. Register writes do not disturb
// the counters.
// ----------------------------------------------------------------------------
module nonzero_coordinate_emitter #(
  parameter int MAX_RANK      = 6,
  parameter int DIM_WIDTH     = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // element input
  input  logic                           in_push,
  output logic                           in_full,
  input  logic signed [ELEMENT_WIDTH-1:0] in_element_value,
  // coordinate output
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [nce_pkg::COORD_W-1:0]    out_coordinate,
  output logic [nce_pkg::DIM_IDX_W-1:0]  out_dimension,
  output logic                           out_last_of_tuple,
  // APB configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [nce_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [nce_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [nce_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import nce_pkg::*;

  localparam int ACT_DIMS = (MAX_RANK < NUM_DIM_REGS) ? MAX_RANK : NUM_DIM_REGS;
  localparam int TUPLE_W  = ACT_DIMS * COORD_W + RANK_W;

  nce_cfg_t           cfg;
  logic               q_push, q_full, q_pop, q_empty;
  logic [TUPLE_W-1:0] q_wdata, q_rdata;

  // register file
  nce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // front: odometer and nonzero detect
  nce_front #(
    .MAX_RANK      (MAX_RANK),
    .DIM_WIDTH     (DIM_WIDTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .push          (in_push),
    .full          (in_full),
    .element_value (in_element_value),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_wdata       (q_wdata)
  );

  // tuple queue decouples element intake from coordinate drain
  nce_fifo #(
    .WIDTH (TUPLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: one coordinate beat per cycle while the consumer keeps popping
  nce_back #(
    .MAX_RANK (MAX_RANK)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_coordinate    (out_coordinate),
    .out_dimension     (out_dimension),
    .out_last_of_tuple (out_last_of_tuple)
  );

endmodule

// ===== hw/rtl/nce_regs.sv =====
// ----------------------------------------------------------------------------
// nce_regs
// APB register file: rank and the six dimension sizes.
// ----------------------------------------------------------------------------
module nce_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nce_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nce_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nce_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output nce_pkg::nce_cfg_t              cfg
);
  import nce_pkg::*;

  logic [RANK_W-1:0]     rank_r;
  logic [DIM_SIZE_W-1:0] dim_r [NUM_DIM_REGS];
  logic [2:0]            idx;
  logic                  wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_W'(1);
      for (int i = 0; i < NUM_DIM_REGS; i++) begin
        dim_r[i] <= DIM_SIZE_W'(1);
      end
    end else if (wr_en) begin
      unique case (nce_reg_idx_t'(idx)) inside
        REG_RANK: rank_r <= pwdata[RANK_W-1:0];
        REG_DIM_0, REG_DIM_1, REG_DIM_2, REG_DIM_3, REG_DIM_4, REG_DIM_5:
          dim_r[idx - 3'(REG_DIM_0)] <= pwdata[DIM_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (nce_reg_idx_t'(idx)) inside
      REG_RANK: prdata = APB_DATA_W'(rank_r);
      REG_DIM_0, REG_DIM_1, REG_DIM_2, REG_DIM_3, REG_DIM_4, REG_DIM_5:
        prdata = APB_DATA_W'(dim_r[idx - 3'(REG_DIM_0)]);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    cfg.rank = rank_r;
    for (int i = 0; i < NUM_DIM_REGS; i++) begin
      cfg.dim_size[i] = dim_r[i];
    end
  end

endmodule

// ===== hw/rtl/nce_front.sv =====
// ----------------------------------------------------------------------------
// nce_front
// Odometer front end: takes one element per beat, advances the coordinate
// counters and queues the coordinate tuple of every nonzero element.
// ----------------------------------------------------------------------------
module nce_front #(
  parameter  int MAX_RANK      = 6,
  parameter  int DIM_WIDTH     = 16,
  parameter  int ELEMENT_WIDTH = 32,
  localparam int ACT_DIMS = (MAX_RANK < nce_pkg::NUM_DIM_REGS) ? MAX_RANK
                                                               : nce_pkg::NUM_DIM_REGS,
  localparam int TUPLE_W  = ACT_DIMS * nce_pkg::COORD_W + nce_pkg::RANK_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nce_pkg::nce_cfg_t               cfg,
  input  logic                            push,
  output logic                            full,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value,
  output logic                            q_push,
  input  logic                            q_full,
  output logic [TUPLE_W-1:0]              q_wdata
);
  import nce_pkg::*;

  // compare width: holds counter + 1 and a dimension size
  localparam int CW = ((DIM_WIDTH > DIM_SIZE_W) ? DIM_WIDTH : DIM_SIZE_W) + 1;
  localparam logic [CW-1:0] SIZE_MASK = CW'((CW'(1) << DIM_WIDTH) - CW'(1));

  logic [DIM_WIDTH-1:0] cnt_r   [MAX_RANK];
  logic [DIM_WIDTH-1:0] cnt_nxt [MAX_RANK];
  logic [RANK_W-1:0]    eff_rank;
  logic [MAX_RANK-1:0]  wrap;
  logic [MAX_RANK-1:0]  carry;
  logic                 accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (element_value != '0);

  // rank zero acts as one, too large saturates
  always_comb begin
    if (cfg.rank == '0) begin
      eff_rank = RANK_W'(1);
    end else if (cfg.rank > RANK_W'(ACT_DIMS)) begin
      eff_rank = RANK_W'(ACT_DIMS);
    end else begin
      eff_rank = cfg.rank;
    end
  end

  // odometer step: innermost active dimension always advances,
  // a dimension advances when all deeper active ones wrap
  always_comb begin
    logic c;
    c    = 1'b1;
    wrap = '1;
    for (int k = 0; k < ACT_DIMS; k++) begin
      wrap[k] = (CW'(cnt_r[k]) + CW'(1)) >= (CW'(cfg.dim_size[k]) & SIZE_MASK);
    end
    for (int k = MAX_RANK - 1; k >= 0; k--) begin
      carry[k] = c;
      if (k < int'(eff_rank)) begin
        c = c & wrap[k];
      end
    end
    for (int k = 0; k < MAX_RANK; k++) begin
      if (k >= int'(eff_rank)) begin
        cnt_nxt[k] = '0;
      end else if (carry[k]) begin
        cnt_nxt[k] = wrap[k] ? '0 : cnt_r[k] + DIM_WIDTH'(1);
      end else begin
        cnt_nxt[k] = cnt_r[k];
      end
    end
  end

  // tuple: rank in the low bits, coordinates above, outermost first
  always_comb begin
    logic [CW-1:0] ext;
    q_wdata = '0;
    q_wdata[RANK_W-1:0] = eff_rank;
    for (int k = 0; k < ACT_DIMS; k++) begin
      ext = CW'(cnt_r[k]);
      q_wdata[RANK_W + k*COORD_W +: COORD_W] = ext[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/nce_fifo.sv =====
// ----------------------------------------------------------------------------
// nce_fifo
// Small synchronous FIFO holding coordinate tuples.
// ----------------------------------------------------------------------------
module nce_fifo #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import nce_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hw/rtl/nce_back.sv =====
// ----------------------------------------------------------------------------
// nce_back
// Back end: walks the queued tuple one coordinate per beat into the
// output register.
// ----------------------------------------------------------------------------
module nce_back #(
  parameter  int MAX_RANK = 6,
  localparam int ACT_DIMS = (MAX_RANK < nce_pkg::NUM_DIM_REGS) ? MAX_RANK
                                                               : nce_pkg::NUM_DIM_REGS,
  localparam int TUPLE_W  = ACT_DIMS * nce_pkg::COORD_W + nce_pkg::RANK_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [TUPLE_W-1:0]            q_rdata,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [nce_pkg::COORD_W-1:0]   out_coordinate,
  output logic [nce_pkg::DIM_IDX_W-1:0] out_dimension,
  output logic                          out_last_of_tuple
);
  import nce_pkg::*;

  logic [(1 << DIM_IDX_W)-1:0][COORD_W-1:0] coord;
  logic [RANK_W-1:0]    t_rank;
  logic [DIM_IDX_W-1:0] idx_r;
  logic                 out_valid_r;
  logic [COORD_W-1:0]   coord_r;
  logic [DIM_IDX_W-1:0] dim_r;
  logic                 last_r;
  logic                 load, last;

  always_comb begin
    coord = '0;
    for (int k = 0; k < ACT_DIMS; k++) begin
      coord[k] = q_rdata[RANK_W + k*COORD_W +: COORD_W];
    end
    t_rank = q_rdata[RANK_W-1:0];
    load   = !out_valid_r || out_pop;
    last   = (idx_r == DIM_IDX_W'(t_rank - RANK_W'(1)));
    q_pop  = load && !q_empty && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= last ? '0 : idx_r + DIM_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      coord_r <= coord[idx_r];
      dim_r   <= idx_r;
      last_r  <= last;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_coordinate    = coord_r;
  assign out_dimension     = dim_r;
  assign out_last_of_tuple = last_r;

endmodule

// ===== hw/rtl/nce_checker.sv =====
// ----------------------------------------------------------------------------
// nce_checker
// Port-level checks on the coordinate output stream.
// ----------------------------------------------------------------------------
module nce_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic [nce_pkg::COORD_W-1:0]   out_coordinate,
  input logic [nce_pkg::DIM_IDX_W-1:0] out_dimension,
  input logic                          out_last_of_tuple
);
  import nce_pkg::*;

  // nothing to show right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // within a tuple the dimensions follow one another with no gap
  a_tuple_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_of_tuple) |=>
      (!out_empty && out_dimension == DIM_IDX_W'($past(out_dimension) + 1'b1)))
    else $error("tuple broken or dimension skipped");

  // a new tuple starts at the outermost dimension
  a_tuple_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_last_of_tuple) |=>
      (out_empty || out_dimension == '0))
    else $error("tuple does not start at dimension zero");

  // a stalled beat holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_coordinate) && $stable(out_dimension)
       && $stable(out_last_of_tuple)))
    else $error("stalled result changed");

endmodule

bind nonzero_coordinate_emitter nce_checker u_nce_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_coordinate    (out_coordinate),
  .out_dimension     (out_dimension),
  .out_last_of_tuple (out_last_of_tuple)
);
